// File: sv/bmba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by every other file of the block except bmba_ram.
`timescale 1ns / 1ps

package bmba_pkg;

   localparam int OP_W       = 2;
   localparam int IDX_W      = 12;
   localparam int CNT_W      = 13;
   localparam int ST_W       = 2;
   localparam int RUN_W      = 14;
   localparam int POS_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [OP_W-1:0] {
      OP_REBUILD = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_FREE    = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL     = 2'd0,
      CSR_RES_FIRST = 2'd1,
      CSR_RES_LAST  = 2'd2
   } csr_index_type;

   // per-word result of the scan / count logic
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
      logic [RUN_W-1:0] run;
      logic [POS_W-1:0] pop;
   } word_res_type;

endpackage

// File: sv/bmba_if.sv
// Request and response channel interfaces of the bitmap block allocator.
// Depends on bmba_pkg for field widths.
`timescale 1ns / 1ps

interface bmba_req_if import bmba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [IDX_W-1:0] block_index;
   logic [CNT_W-1:0] run_length;

   modport source (output valid, opcode, block_index, run_length, input ready);
   modport sink   (input valid, opcode, block_index, run_length, output ready);
endinterface

interface bmba_rsp_if import bmba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [IDX_W-1:0] first_block;
   logic [CNT_W-1:0] changed_blocks;
   logic [CNT_W-1:0] free_blocks;

   modport source (output valid, status, first_block, changed_blocks, free_blocks,
                   input ready);
   modport sink   (input valid, status, first_block, changed_blocks, free_blocks,
                   output ready);
endinterface

// File: sv/bitmap_block_allocator_unit.sv
// Bitmap block allocator: a usage bitmap in one RAM, one bit per block
// (1 used), with rebuild, first-fit allocate and free. Uses bmba_pkg,
// bmba_if, bmba_ram and bmba_word_unit.
//
// Usage: write total_blocks, reserved_first_block and reserved_last_block
// through the csr_ port while idle, then send a rebuild beat on req_ch.
// Each request beat yields exactly one response beat on rsp_ch with status,
// first block of an allocation, blocks changed and the free count after it.
// Items are processed one at a time, one map word per cycle:
//   rebuild   one write per word
//   allocate  a word-by-word scan of up to MAP_WORDS words (one RAM read
//             per word), then a read-modify-write of each word of the run
//             to mark it, after priming the read
//   free      read-modify-write of each word spanned by the range
//   zero-count allocate or unused opcode: straight to the response.
// The RAM read port, one word per cycle, sets this pace.
// After reset the map is filled with ones (every block used), one word a
// cycle, during which no request is taken.
// The response sits in an output register; a stalled receiver holds it and
// the next item runs meanwhile, finishing only once that beat has gone.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit import bmba_pkg::*; #(
   parameter int NUM_BLOCKS = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   bmba_req_if.sink              req_ch,
   bmba_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WSH       = $clog2(WORD_BITS);
   localparam int BW        = (AW + WSH + 1 > 15) ? AW + WSH + 1 : 15;
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_REBUILD = 7'b0000100,
      S_SCAN    = 7'b0001000,
      S_MARK    = 7'b0010000,
      S_FREE    = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cfg_total_ff, cfg_total_in;
   logic [IDX_W-1:0] cfg_rf_ff, cfg_rf_in, cfg_rl_ff, cfg_rl_in;
   logic [CNT_W-1:0] tot_ff, tot_in, cnt_ff, cnt_in;
   logic [IDX_W-1:0] rf_ff, rf_in, rl_ff, rl_in;
   logic [BW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in, dat_addr_ff, dat_addr_in;
   logic [AW-1:0]    last_word_ff, last_word_in;
   logic             dat_vld_ff, dat_vld_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0] changed_ff, changed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_first_ff, rsp_first_in;
   logic [CNT_W-1:0] rsp_changed_ff, rsp_changed_in;
   logic [CNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
   logic [WORD_BITS-1:0] vmask, rmask, rb_free, rb_res;
   logic [BW-1:0]        base_rd, base_wr, end_blk, start_blk, free_end, free_hi;
   logic [CNT_W-1:0]     tot_lim, rb_hi, rb_ov;
   word_res_type         wres;
   logic                 req_acc;

   function automatic logic [POS_W-1:0] clampk(input logic [BW-1:0] x,
                                               input logic [BW-1:0] b);
      logic [BW-1:0] d;
      d = x - b;
      if (x <= b) begin
         return '0;
      end else if (d >= BW'(WORD_BITS)) begin
         return POS_W'(WORD_BITS);
      end else begin
         return POS_W'(d);
      end
   endfunction

   function automatic logic [WORD_BITS-1:0] below(input logic [POS_W-1:0] k);
      logic [WORD_BITS-1:0] m;
      for (int j = 0; j < WORD_BITS; j++) begin
         m[j] = (POS_W'(j) < k);
      end
      return m;
   endfunction

   bmba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr_ff),
      .rdata (ram_rdata)
   );

   bmba_word_unit #(.WORD_BITS(WORD_BITS)) u_word (
      .word   (ram_rdata),
      .vmask  (vmask),
      .rmask  (rmask),
      .run_in (run_ff),
      .cnt    (cnt_ff),
      .res    (wres)
   );

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign req_acc               = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.first_block    = rsp_first_ff;
   assign rsp_ch.changed_blocks = rsp_changed_ff;
   assign rsp_ch.free_blocks    = rsp_free_ff;

   assign tot_lim = (32'(cfg_total_ff) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : cfg_total_ff;
   assign base_rd = BW'(dat_addr_ff) << WSH;
   assign base_wr = BW'(rd_addr_ff) << WSH;

   assign vmask = below(clampk(BW'(tot_ff), base_rd));
   assign rmask = below(clampk(hi_ff, base_rd)) & ~below(clampk(lo_ff, base_rd));

   // rebuild word: free below total, reserved range kept used
   assign rb_res  = (rf_ff <= rl_ff) ?
                    (below(clampk(BW'(rl_ff) + BW'(1), base_wr)) &
                     ~below(clampk(BW'(rf_ff), base_wr))) : '0;
   assign rb_free = below(clampk(BW'(tot_ff), base_wr)) & ~rb_res;
   assign rb_hi   = ((CNT_W'(rl_ff) + CNT_W'(1)) < tot_ff) ?
                    (CNT_W'(rl_ff) + CNT_W'(1)) : tot_ff;
   assign rb_ov   = (rf_ff <= rl_ff && CNT_W'(rf_ff) < tot_ff) ?
                    (rb_hi - CNT_W'(rf_ff)) : '0;

   assign end_blk   = base_rd + BW'(wres.pos);
   assign start_blk = end_blk + BW'(1) - BW'(cnt_ff);
   assign free_end  = BW'(req_ch.block_index) + BW'(req_ch.run_length);
   assign free_hi   = (free_end < BW'(tot_lim)) ? free_end : BW'(tot_lim);

   always_comb begin
      state_in      = state_ff;
      cfg_total_in  = cfg_total_ff;
      cfg_rf_in     = cfg_rf_ff;
      cfg_rl_in     = cfg_rl_ff;
      tot_in        = tot_ff;
      cnt_in        = cnt_ff;
      rf_in         = rf_ff;
      rl_in         = rl_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rd_addr_in    = rd_addr_ff;
      dat_addr_in   = dat_addr_ff;
      dat_vld_in    = 1'b0;
      last_word_in  = last_word_ff;
      run_in        = run_ff;
      free_count_in = free_count_ff;
      status_in     = status_ff;
      first_in      = first_ff;
      changed_in    = changed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_free_in   = rsp_free_ff;
      ram_we        = 1'b0;
      ram_waddr     = dat_addr_ff;
      ram_wdata     = ram_rdata;

      if (csr_we) begin
         case (csr_index)
            CSR_TOTAL:     cfg_total_in = csr_wdata;
            CSR_RES_FIRST: cfg_rf_in    = csr_wdata[IDX_W-1:0];
            CSR_RES_LAST:  cfg_rl_in    = csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = rd_addr_ff;
            ram_wdata  = '1;
            rd_addr_in = rd_addr_ff + AW'(1);
            if (rd_addr_ff == LAST_WORD) begin
               rd_addr_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               tot_in     = tot_lim;
               cnt_in     = req_ch.run_length;
               rf_in      = cfg_rf_ff;
               rl_in      = cfg_rl_ff;
               run_in     = '0;
               rd_addr_in = '0;
               status_in  = ST_OK;
               first_in   = '0;
               changed_in = '0;
               case (req_ch.opcode)
                  OP_REBUILD: state_in = S_REBUILD;
                  OP_ALLOC: begin
                     if (req_ch.run_length == '0) begin
                        status_in = ST_NOFIT;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (req_ch.run_length != '0 && free_end > BW'(tot_lim)) begin
                        status_in = ST_RANGE;
                     end
                     lo_in        = BW'(req_ch.block_index);
                     hi_in        = free_hi;
                     rd_addr_in   = AW'(BW'(req_ch.block_index) >> WSH);
                     last_word_in = AW'((free_hi - BW'(1)) >> WSH);
                     if (BW'(req_ch.block_index) >= free_hi) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_REBUILD: begin
            ram_we     = 1'b1;
            ram_waddr  = rd_addr_ff;
            ram_wdata  = ~rb_free;
            rd_addr_in = rd_addr_ff + AW'(1);
            if (rd_addr_ff == LAST_WORD) begin
               free_count_in = tot_ff - rb_ov;
               state_in      = S_DONE;
            end
         end
         S_SCAN: begin
            rd_addr_in  = rd_addr_ff + AW'(1);
            dat_vld_in  = 1'b1;
            dat_addr_in = rd_addr_ff;
            if (dat_vld_ff) begin
               if (wres.found) begin
                  lo_in         = start_blk;
                  hi_in         = end_blk + BW'(1);
                  rd_addr_in    = AW'(start_blk >> WSH);
                  last_word_in  = dat_addr_ff;
                  dat_vld_in    = 1'b0;
                  first_in      = IDX_W'(start_blk);
                  changed_in    = cnt_ff;
                  free_count_in = free_count_ff - cnt_ff;
                  state_in      = S_MARK;
               end else if (dat_addr_ff == LAST_WORD) begin
                  status_in = ST_NOFIT;
                  state_in  = S_DONE;
               end else begin
                  run_in = wres.run;
               end
            end
         end
         S_MARK, S_FREE: begin
            rd_addr_in  = rd_addr_ff + AW'(1);
            dat_vld_in  = 1'b1;
            dat_addr_in = rd_addr_ff;
            if (dat_vld_ff) begin
               ram_we = 1'b1;
               if (state_ff == S_MARK) begin
                  ram_wdata = ram_rdata | rmask;
               end else begin
                  ram_wdata     = ram_rdata & ~rmask;
                  changed_in    = changed_ff + CNT_W'(wres.pop);
                  free_count_in = free_count_ff + CNT_W'(wres.pop);
               end
               if (dat_addr_ff == last_word_ff) begin
                  dat_vld_in = 1'b0;
                  state_in   = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_first_in   = first_ff;
               rsp_changed_in = changed_ff;
               rsp_free_in    = free_count_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cfg_total_ff  <= '0;
         cfg_rf_ff     <= '0;
         cfg_rl_ff     <= '0;
         rd_addr_ff    <= '0;
         dat_vld_ff    <= 1'b0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_total_ff  <= cfg_total_in;
         cfg_rf_ff     <= cfg_rf_in;
         cfg_rl_ff     <= cfg_rl_in;
         rd_addr_ff    <= rd_addr_in;
         dat_vld_ff    <= dat_vld_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tot_ff         <= tot_in;
      cnt_ff         <= cnt_in;
      rf_ff          <= rf_in;
      rl_ff          <= rl_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      dat_addr_ff    <= dat_addr_in;
      last_word_ff   <= last_word_in;
      run_ff         <= run_in;
      status_ff      <= status_in;
      first_ff       <= first_in;
      changed_ff     <= changed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_free_ff    <= rsp_free_in;
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_we)
      else $error("map written while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("accepted beat did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

   a_free_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_count_ff) <= NUM_BLOCKS)
      else $error("free count beyond map size");

endmodule

// File: sv/bmba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bmba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/bmba_word_unit.sv
// Per-word logic: first-fit run search across one map word and popcount
// of the bits under a range mask. Depends on bmba_pkg.
`timescale 1ns / 1ps

module bmba_word_unit import bmba_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic [WORD_BITS-1:0] vmask,   // blocks below the total
   input  logic [WORD_BITS-1:0] rmask,   // blocks inside the current range
   input  logic [RUN_W-1:0]     run_in,
   input  logic [CNT_W-1:0]     cnt,
   output word_res_type         res
);

   logic [WORD_BITS-1:0] free_v;
   logic [RUN_W-1:0]     run_a [WORD_BITS];
   logic [WORD_BITS-1:0] sel;

   assign free_v = ~word & vmask;
   assign sel    = word & rmask;

   // run of free blocks ending at each bit
   always_comb begin
      logic             seen;
      logic [POS_W-1:0] p;
      for (int j = 0; j < WORD_BITS; j++) begin
         seen = 1'b0;
         p    = '0;
         for (int k = 0; k <= j; k++) begin
            if (!free_v[k]) begin
               seen = 1'b1;
               p    = POS_W'(k);
            end
         end
         if (!free_v[j]) begin
            run_a[j] = '0;
         end else if (seen) begin
            run_a[j] = RUN_W'(POS_W'(j) - p);
         end else begin
            run_a[j] = run_in + RUN_W'(j + 1);
         end
      end
   end

   always_comb begin
      res       = '0;
      res.run   = run_a[WORD_BITS-1];
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (cnt != '0 && run_a[j] >= RUN_W'(cnt)) begin
            res.found = 1'b1;
            res.pos   = POS_W'(j);
         end
      end
      for (int j = 0; j < WORD_BITS; j++) begin
         res.pop = res.pop + POS_W'(sel[j]);
      end
   end

endmodule
